>>> sv/gaussian_blur_3x3_macros.svh
// assertion helpers shared by the blur modules
`ifndef GAUSSIAN_BLUR_3X3_MACROS_SVH
`define GAUSSIAN_BLUR_3X3_MACROS_SVH

// checked at every rising edge outside reset
`define GB3_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every rising edge, reset included
`define GB3_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/gb3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gb3_pkg;

  localparam int MAX_WIDTH    = 2048;
  localparam int MIN_WIDTH    = 3;
  localparam int HEIGHT_LIMIT = 4096;
  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  localparam int PIX_W  = 8;
  localparam int FW_W   = 12;                       // frame_width register
  localparam int FH_W   = 13;                       // frame_height register
  localparam int COL_W  = $clog2(MAX_WIDTH);        // column / line store address
  localparam int WID_W  = $clog2(MAX_WIDTH + 1);    // used width, holds MAX_WIDTH
  localparam int ROW_W  = $clog2(HEIGHT_LIMIT + 2); // input row, runs to height + 1
  localparam int OROW_W = $clog2(HEIGHT_LIMIT);     // output row
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [COL_W-1:0]  col_t;
  typedef logic [WID_W-1:0]  wid_t;
  typedef logic [FH_W-1:0]   hgt_t;

  // frame geometry in use, plus a restart pulse on every register write
  typedef struct packed {
    wid_t width;
    hgt_t height;
    logic restart;
  } cfg_ctl_t;

  // everything one accepted transaction needs downstream
  typedef struct packed {
    col_t slot;
    pix_t pix;
    logic near_ok;    // row above exists in this frame
    logic far_ok;     // row two above exists in this frame
    logic emit;
    logic left_zero;
    logic right_zero;
    logic last;
  } item_t;

endpackage
`default_nettype wire

>>> sv/gb3_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface gb3_in_if;
  logic              valid;
  logic              ready;
  logic              kind;
  gb3_pkg::pix_t     pixel;

  modport source (output valid, output kind, output pixel, input ready);
  modport sink   (input valid, input kind, input pixel, output ready);
endinterface

interface gb3_out_if;
  logic              valid;
  logic              ready;
  gb3_pkg::pix_t     filtered;
  logic              frame_end;

  modport source (output valid, output filtered, output frame_end, input ready);
  modport sink   (input valid, input filtered, input frame_end, output ready);
endinterface
`default_nettype wire

>>> sv/gb3_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
module gb3_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [gb3_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [gb3_pkg::DATA_W-1:0]  pwdata,
  output logic      [gb3_pkg::DATA_W-1:0]  prdata,
  output logic                             pready,
  output gb3_pkg::cfg_ctl_t                ctl
);
  import gb3_pkg::*;

  logic [FW_W-1:0] width_r, width_nxt;
  logic [FH_W-1:0] height_r, height_nxt;
  wid_t            used_w_r, used_w_nxt;
  hgt_t            used_h_r, used_h_nxt;
  logic            wr_en;
  logic            reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (wr_en) begin
      unique case (reg_sel)
        REG_WIDTH:  width_nxt  = pwdata[FW_W-1:0];
        REG_HEIGHT: height_nxt = pwdata[FH_W-1:0];
        default:    ;
      endcase
    end
    // saturate to the supported range
    if (32'(width_nxt) < MIN_WIDTH) begin
      used_w_nxt = WID_W'(MIN_WIDTH);
    end else if (32'(width_nxt) > MAX_WIDTH) begin
      used_w_nxt = WID_W'(MAX_WIDTH);
    end else begin
      used_w_nxt = WID_W'(width_nxt);
    end
    if (height_nxt == '0) begin
      used_h_nxt = FH_W'(1);
    end else if (32'(height_nxt) > HEIGHT_LIMIT) begin
      used_h_nxt = FH_W'(HEIGHT_LIMIT);
    end else begin
      used_h_nxt = height_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= FW_W'(RESET_WIDTH);
      height_r <= FH_W'(RESET_HEIGHT);
      used_w_r <= WID_W'(RESET_WIDTH);
      used_h_r <= FH_W'(RESET_HEIGHT);
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      used_w_r <= used_w_nxt;
      used_h_r <= used_h_nxt;
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_WIDTH:  prdata = DATA_W'(width_r);
      REG_HEIGHT: prdata = DATA_W'(height_r);
      default:    prdata = '0;
    endcase
  end

  // geometry switches at the same edge that restarts the counters
  assign ctl.width   = used_w_r;
  assign ctl.height  = used_h_r;
  assign ctl.restart = wr_en;

endmodule
`default_nettype wire

>>> sv/gb3_raster.sv
`timescale 1ns / 1ps
`default_nettype none
`include "gaussian_blur_3x3_macros.svh"
module gb3_raster (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire gb3_pkg::cfg_ctl_t  ctl,
  input  wire logic               accept,
  input  wire logic               kind,
  input  wire gb3_pkg::pix_t      pixel,
  output gb3_pkg::item_t          item
);
  import gb3_pkg::*;

  col_t              in_col_r, in_col_nxt;
  logic [ROW_W-1:0]  in_row_r, in_row_nxt;
  col_t              out_col_r, out_col_nxt;
  logic [OROW_W-1:0] out_row_r, out_row_nxt;
  wid_t              in_col_inc;
  wid_t              out_col_inc;
  logic [FH_W-1:0]   out_row_inc;
  logic [ROW_W-1:0]  height_ext;
  logic              in_wrap;
  logic              out_wrap;

  assign height_ext  = ROW_W'(ctl.height);
  assign in_col_inc  = WID_W'(in_col_r) + WID_W'(1);
  assign out_col_inc = WID_W'(out_col_r) + WID_W'(1);
  assign out_row_inc = FH_W'(out_row_r) + FH_W'(1);
  assign in_wrap     = in_col_inc >= ctl.width;
  assign out_wrap    = out_col_inc >= ctl.width;

  always_comb begin
    item.slot       = in_col_r;
    item.pix        = (kind == KIND_PIXEL && in_row_r < height_ext) ? pixel : '0;
    item.near_ok    = in_row_r >= ROW_W'(1);
    item.far_ok     = in_row_r >= ROW_W'(2);
    // linear position has reached width + 1
    item.emit       = (in_row_r >= ROW_W'(2)) ||
                      (in_row_r == ROW_W'(1) && in_col_r != '0);
    item.left_zero  = out_col_r == '0;
    item.right_zero = out_wrap;
    item.last       = out_wrap && (out_row_inc >= ctl.height);
  end

  always_comb begin
    in_col_nxt  = in_col_r;
    in_row_nxt  = in_row_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (ctl.restart || (accept && item.emit && item.last)) begin
      in_col_nxt  = '0;
      in_row_nxt  = '0;
      out_col_nxt = '0;
      out_row_nxt = '0;
    end else if (accept) begin
      if (in_wrap) begin
        in_col_nxt = '0;
        if (in_row_r <= height_ext) begin
          in_row_nxt = in_row_r + ROW_W'(1);
        end
      end else begin
        in_col_nxt = COL_W'(in_col_inc);
      end
      if (item.emit) begin
        if (out_wrap) begin
          out_col_nxt = '0;
          out_row_nxt = out_row_r + OROW_W'(1);
        end else begin
          out_col_nxt = COL_W'(out_col_inc);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      in_row_r  <= in_row_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
    end
  end

  `GB3_ASSERT(a_col_in_frame, WID_W'(in_col_r) < ctl.width, "input column past frame width")
  `GB3_ASSERT(a_last_restarts, accept && item.emit && item.last && !ctl.restart |=> in_col_r == '0 && in_row_r == '0 && out_col_r == '0, "frame end did not restart the raster")

endmodule
`default_nettype wire

>>> sv/gb3_linebuf.sv
`timescale 1ns / 1ps
`default_nettype none
module gb3_linebuf (
  input  wire logic           clk,
  input  wire logic           rd_en,
  input  wire gb3_pkg::col_t  rd_addr,
  input  wire logic           wr_en,
  input  wire gb3_pkg::col_t  wr_addr,
  input  wire gb3_pkg::pix_t  wr_near,
  input  wire gb3_pkg::pix_t  wr_far,
  output gb3_pkg::pix_t       near_q,
  output gb3_pkg::pix_t       far_q
);
  import gb3_pkg::*;

  pix_t near_mem [MAX_WIDTH];
  pix_t far_mem  [MAX_WIDTH];
  pix_t near_q_r;
  pix_t far_q_r;

  // the far store takes what falls out of the near store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      near_mem[wr_addr] <= wr_near;
      far_mem[wr_addr]  <= wr_far;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      near_q_r <= near_mem[rd_addr];
      far_q_r  <= far_mem[rd_addr];
    end
  end

  assign near_q = near_q_r;
  assign far_q  = far_q_r;

endmodule
`default_nettype wire

>>> sv/gb3_window.sv
`timescale 1ns / 1ps
`default_nettype none
module gb3_window (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           clear,
  input  wire logic           shift,
  input  wire gb3_pkg::pix_t  top_px,
  input  wire gb3_pkg::pix_t  mid_px,
  input  wire gb3_pkg::pix_t  bot_px,
  input  wire logic           left_zero,
  input  wire logic           right_zero,
  output gb3_pkg::pix_t       filtered
);
  import gb3_pkg::*;

  localparam int COLSUM_W = PIX_W + 2;
  localparam int SUM_W    = PIX_W + 4;

  pix_t                win_r   [3][3];
  pix_t                win_nxt [3][3];
  pix_t                fresh   [3];
  logic [COLSUM_W-1:0] row_sum [3];
  logic [SUM_W-1:0]    total;

  assign fresh[0] = top_px;
  assign fresh[1] = mid_px;
  assign fresh[2] = bot_px;

  // column 0 oldest, column 2 newest
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r][0] = win_r[r][1];
      win_nxt[r][1] = win_r[r][2];
      win_nxt[r][2] = fresh[r];
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      row_sum[r] = (left_zero ? COLSUM_W'(0) : COLSUM_W'(win_nxt[r][0])) +
                   {1'b0, win_nxt[r][1], 1'b0} +
                   (right_zero ? COLSUM_W'(0) : COLSUM_W'(win_nxt[r][2]));
    end
    total = SUM_W'(row_sum[0]) + {1'b0, row_sum[1], 1'b0} + SUM_W'(row_sum[2]);
  end

  assign filtered = total[SUM_W-1:4];

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else if (shift) begin
      win_r <= win_nxt;
    end
  end

endmodule
`default_nettype wire

>>> sv/gaussian_blur_3x3.sv
`timescale 1ns / 1ps
`default_nettype none
`include "gaussian_blur_3x3_macros.svh"
// channel   direction  transaction
// in_ch     sink       one pixel or flush tick, raster order
// out_ch    source     one blurred pixel, frame_end on the last one
// apb       slave      frame_width at 0x0, frame_height at 0x4
//
// one transaction per cycle sustained unless a held result stalls the stage; the
// last neighbor of a pixel passes line store read, then window sum into the output register
// output lags input by one row plus one pixel, flush ticks drain the frame
// rst_n is synchronous; line stores are not cleared, rows not yet written are masked
// only a stage holding a result waits on out_ch.ready, flush-only work keeps moving
module gaussian_blur_3x3 (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  gb3_in_if.sink                           in_ch,
  gb3_out_if.source                        out_ch,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [gb3_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [gb3_pkg::DATA_W-1:0]  pwdata,
  output logic      [gb3_pkg::DATA_W-1:0]  prdata,
  output logic                             pready
);
  import gb3_pkg::*;

  cfg_ctl_t ctl;
  item_t    item;
  item_t    stage_r, stage_nxt;
  logic     stage_vld_r, stage_vld_nxt;
  logic     out_vld_r, out_vld_nxt;
  pix_t     filt_r, filt_nxt;
  logic     fend_r, fend_nxt;
  logic     in_acc;
  logic     adv;
  pix_t     near_q, far_q;
  pix_t     near_px, far_px;
  pix_t     sum_px;

  gb3_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .ctl     (ctl)
  );

  gb3_raster u_raster (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (ctl),
    .accept (in_acc),
    .kind   (in_ch.kind),
    .pixel  (in_ch.pixel),
    .item   (item)
  );

  gb3_linebuf u_linebuf (
    .clk     (clk),
    .rd_en   (in_acc),
    .rd_addr (item.slot),
    .wr_en   (adv),
    .wr_addr (stage_r.slot),
    .wr_near (stage_r.pix),
    .wr_far  (near_px),
    .near_q  (near_q),
    .far_q   (far_q)
  );

  assign near_px = stage_r.near_ok ? near_q : '0;
  assign far_px  = stage_r.far_ok ? far_q : '0;

  gb3_window u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .clear      (ctl.restart),
    .shift      (adv),
    .top_px     (far_px),
    .mid_px     (near_px),
    .bot_px     (stage_r.pix),
    .left_zero  (stage_r.left_zero),
    .right_zero (stage_r.right_zero),
    .filtered   (sum_px)
  );

  // a transaction with no result never waits on the output side
  assign adv          = stage_vld_r && (!stage_r.emit || !out_vld_r || out_ch.ready);
  assign in_ch.ready  = !stage_vld_r || adv;
  assign in_acc       = in_ch.valid && in_ch.ready;

  always_comb begin
    stage_nxt     = stage_r;
    stage_vld_nxt = stage_vld_r;
    if (in_acc) begin
      stage_nxt     = item;
      stage_vld_nxt = 1'b1;
    end else if (adv) begin
      stage_vld_nxt = 1'b0;
    end
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    filt_nxt    = filt_r;
    fend_nxt    = fend_r;
    if (adv && stage_r.emit) begin
      out_vld_nxt = 1'b1;
      filt_nxt    = sum_px;
      fend_nxt    = stage_r.last;
    end else if (out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_vld_r <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      stage_vld_r <= stage_vld_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stage_r <= stage_nxt;
    filt_r  <= filt_nxt;
    fend_r  <= fend_nxt;
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.filtered  = filt_r;
  assign out_ch.frame_end = fend_r;

  `GB3_ASSERT(a_stall_only_on_result, stage_vld_r && !adv |-> stage_r.emit && out_vld_r && !out_ch.ready, "pipeline stage held without a blocked result")
  `GB3_ASSERT(a_store_collision, in_acc && adv && item.slot == stage_r.slot |-> !item.near_ok, "line store read and write hit one entry in a live row")
  `GB3_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !stage_vld_r && !out_vld_r, "pipeline not empty after reset")

endmodule
`default_nettype wire

>>> sim/gaussian_blur_3x3_tb.sv
`timescale 1ns / 1ps
module gaussian_blur_3x3_tb;
  import gb3_pkg::*;

  localparam int unsigned RUN_LIMIT     = 1_500_000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES   = 300;

  typedef struct packed {
    pix_t filtered;
    logic frame_end;
  } blur_out_t;

  typedef struct packed {
    logic kind;
    pix_t pixel;
    bit   typed;
    pix_t filtered;
    logic frame_end;
  } stim_row_t;

  // frame 3x1 of 255, then a frame of zeros with a flush inside and pixels
  // during the drain, then 0 255 0, then the start of a frame cut short
  localparam int N_DIRECTED = 24;
  localparam stim_row_t DIRECTED [0:N_DIRECTED-1] = '{
    '{KIND_PIXEL, 8'd255, 1'b0, 8'd0,   1'b0},
    '{KIND_PIXEL, 8'd255, 1'b0, 8'd0,   1'b0},
    '{KIND_PIXEL, 8'd255, 1'b0, 8'd0,   1'b0},
    '{KIND_FLUSH, 8'd0,   1'b0, 8'd0,   1'b0},
    '{KIND_FLUSH, 8'd0,   1'b1, 8'd95,  1'b0},
    '{KIND_FLUSH, 8'd0,   1'b1, 8'd127, 1'b0},
    '{KIND_FLUSH, 8'd0,   1'b1, 8'd95,  1'b1},
    '{KIND_PIXEL, 8'd0,   1'b0, 8'd0,   1'b0},
    '{KIND_FLUSH, 8'hA5,  1'b0, 8'd0,   1'b0},
    '{KIND_PIXEL, 8'd0,   1'b0, 8'd0,   1'b0},
    '{KIND_PIXEL, 8'd255, 1'b0, 8'd0,   1'b0},
    '{KIND_PIXEL, 8'd255, 1'b1, 8'd0,   1'b0},
    '{KIND_PIXEL, 8'd200, 1'b1, 8'd0,   1'b0},
    '{KIND_PIXEL, 8'd255, 1'b1, 8'd0,   1'b1},
    '{KIND_PIXEL, 8'd0,   1'b0, 8'd0,   1'b0},
    '{KIND_PIXEL, 8'd255, 1'b0, 8'd0,   1'b0},
    '{KIND_PIXEL, 8'd0,   1'b0, 8'd0,   1'b0},
    '{KIND_FLUSH, 8'd0,   1'b0, 8'd0,   1'b0},
    '{KIND_FLUSH, 8'd0,   1'b1, 8'd31,  1'b0},
    '{KIND_FLUSH, 8'd0,   1'b1, 8'd63,  1'b0},
    '{KIND_FLUSH, 8'd0,   1'b1, 8'd31,  1'b1},
    '{KIND_PIXEL, 8'h01,  1'b0, 8'd0,   1'b0},
    '{KIND_PIXEL, 8'h80,  1'b0, 8'd0,   1'b0},
    '{KIND_PIXEL, 8'hFE,  1'b0, 8'd0,   1'b0}
  };

  logic clk;
  logic rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  gb3_in_if  in_ch ();
  gb3_out_if out_ch ();

  gaussian_blur_3x3 u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // blur predictor state
  logic [FW_W-1:0] cfg_width;
  logic [FH_W-1:0] cfg_height;
  pix_t line_up1 [0:MAX_WIDTH-1];
  pix_t line_up2 [0:MAX_WIDTH-1];
  pix_t nbhd [0:8];   // [row * 3 + col], col 2 newest
  int unsigned col_in, row_in, col_out, row_out;

  blur_out_t   blur_due [$];
  int unsigned fails;
  int unsigned cycles;
  int unsigned src_calm;
  int unsigned sink_calm;
  bit          hold_off_req;

  function automatic int unsigned eff_width();
    int unsigned w;
    w = cfg_width;
    if (w < MIN_WIDTH) w = MIN_WIDTH;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic int unsigned eff_height();
    int unsigned h;
    h = cfg_height;
    if (h < 1) h = 1;
    if (h > HEIGHT_LIMIT) h = HEIGHT_LIMIT;
    return h;
  endfunction

  function automatic void restart_frame();
    int i;
    col_in = 0;
    row_in = 0;
    col_out = 0;
    row_out = 0;
    for (i = 0; i < 9; i++) nbhd[i] = '0;
  endfunction

  function automatic void blur_model_reset();
    int i;
    cfg_width = FW_W'(RESET_WIDTH);
    cfg_height = FH_W'(RESET_HEIGHT);
    for (i = 0; i < MAX_WIDTH; i++) begin
      line_up1[i] = '0;
      line_up2[i] = '0;
    end
    restart_frame();
  endfunction

  // advances the predictor by one transaction, returns 1 when a pixel comes out
  function automatic bit blur_window_step(input logic k, input pix_t p, output blur_out_t res);
    int unsigned w, h, ic, ir, slot, sum, lft, rgt;
    int unsigned colsum [0:2];
    int r;
    pix_t v, b, a;
    bit emit, last;
    w = eff_width();
    h = eff_height();
    ic = col_in;
    ir = row_in;
    slot = (ic < MAX_WIDTH) ? ic : 0;
    v = (k == KIND_PIXEL && ir < h) ? p : '0;
    b = (ir >= 1) ? line_up1[slot] : '0;
    a = (ir >= 2) ? line_up2[slot] : '0;
    line_up2[slot] = b;
    line_up1[slot] = v;
    for (r = 0; r < 3; r++) begin
      nbhd[r*3]   = nbhd[r*3+1];
      nbhd[r*3+1] = nbhd[r*3+2];
    end
    nbhd[2] = a;
    nbhd[5] = b;
    nbhd[8] = v;
    emit = (ir >= 2) || (ir == 1 && ic >= 1);
    ic++;
    if (ic >= w) begin
      ic = 0;
      if (ir <= h) ir++;
    end
    col_in = ic;
    row_in = ir;
    res = '0;
    if (!emit) return 1'b0;
    for (r = 0; r < 3; r++) begin
      lft = (col_out == 0) ? 0 : nbhd[r*3];
      rgt = (col_out + 1 >= w) ? 0 : nbhd[r*3+2];
      colsum[r] = lft + 2 * nbhd[r*3+1] + rgt;
    end
    sum = colsum[0] + 2 * colsum[1] + colsum[2];
    last = (row_out + 1 >= h) && (col_out + 1 >= w);
    res.filtered = pix_t'(sum >> 4);
    res.frame_end = last;
    if (last) begin
      col_in = 0;
      row_in = 0;
      col_out = 0;
      row_out = 0;
    end else begin
      col_out++;
      if (col_out >= w) begin
        col_out = 0;
        row_out++;
      end
    end
    return 1'b1;
  endfunction

  // mostly no gap, some short ones, a few long, and calm stretches
  function automatic int unsigned idle_len(inout int unsigned calm);
    int unsigned r;
    if (calm != 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      calm = $urandom_range(20, 150);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  function automatic pix_t pick_pixel();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return pix_t'($urandom_range(0, 255));
  endfunction

  task automatic write_reg(input logic idx, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_WIDTH) cfg_width = data[FW_W-1:0];
    else cfg_height = data[FH_W-1:0];
    restart_frame();
    @(posedge clk);
  endtask

  task automatic feed(input logic k, input pix_t p, input bit typed, input blur_out_t typed_px);
    blur_out_t got;
    bit emit;
    int unsigned gap;
    in_ch.valid <= 1'b1;
    in_ch.kind  <= k;
    in_ch.pixel <= p;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    emit = blur_window_step(k, p, got);
    if (typed) blur_due.push_back(typed_px);
    else if (emit) blur_due.push_back(got);
    gap = idle_len(src_calm);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // flush-only work has no result, so give the pipeline time to empty
  task automatic settle();
    while (blur_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [DATA_W-1:0] wdata, input logic [DATA_W-1:0] hdata,
                           input int n, input bit hold);
    logic k;
    int i;
    settle();
    write_reg(REG_WIDTH, ($urandom() & 32'hFFFF_F000) | wdata);
    write_reg(REG_HEIGHT, ($urandom() & 32'hFFFF_E000) | hdata);
    if (hold) hold_off_req = 1'b1;
    for (i = 0; i < n; i++) begin
      // well-formed frames with a few flushes inside and a few pixels in the drain
      if (row_in < eff_height()) k = ($urandom_range(0, 99) < 6) ? KIND_FLUSH : KIND_PIXEL;
      else k = ($urandom_range(0, 99) < 12) ? KIND_PIXEL : KIND_FLUSH;
      feed(k, pick_pixel(), 1'b0, '0);
    end
    in_ch.valid <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("gaussian_blur_3x3 test failed");
      $finish;
    end
  end

  // result side: checks each transaction, then picks the next ready
  initial begin
    blur_out_t want;
    int unsigned stall_left;
    int unsigned gap;
    bit hold_done;
    stall_left = 0;
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (blur_due.size() == 0) begin
          $error("output transaction with nothing expected: filtered %0d frame_end %0b",
                 out_ch.filtered, out_ch.frame_end);
          fails++;
        end else begin
          want = blur_due.pop_front();
          if (out_ch.filtered !== want.filtered) begin
            $error("filtered: expected %0d, got %0d", want.filtered, out_ch.filtered);
            fails++;
          end
          if (out_ch.frame_end !== want.frame_end) begin
            $error("frame_end: expected %0b, got %0b", want.frame_end, out_ch.frame_end);
            fails++;
          end
        end
      end
      if (hold_off_req && !hold_done) begin
        hold_done = 1'b1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        gap = idle_len(sink_calm);
        if (gap == 0) begin
          out_ch.ready <= 1'b1;
        end else begin
          out_ch.ready <= 1'b0;
          stall_left = gap - 1;
        end
      end
    end
  end

  initial begin
    int i;
    fails = 0;
    cycles = 0;
    src_calm = 0;
    sink_calm = 0;
    hold_off_req = 1'b0;
    blur_model_reset();
    rst_n       <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    in_ch.valid <= 1'b0;
    in_ch.kind  <= KIND_PIXEL;
    in_ch.pixel <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    settle();

    // both registers below range, high bits set: a 3 x 1 frame
    write_reg(REG_WIDTH, 32'hFFFF_F000);
    write_reg(REG_HEIGHT, 32'hFFFF_E000);
    for (i = 0; i < N_DIRECTED; i++) begin
      feed(DIRECTED[i].kind, DIRECTED[i].pixel, DIRECTED[i].typed,
           {DIRECTED[i].filtered, DIRECTED[i].frame_end});
    end
    in_ch.valid <= 1'b0;

    run_phase(32'd4, 32'd3, 170, 1'b0);
    run_phase(32'd7, 32'd5, 260, 1'b1);
    run_phase(32'd3, 32'd8191, 200, 1'b0);
    run_phase(32'd16, 32'd1, 200, 1'b0);
    run_phase(32'd12, 32'd6, 340, 1'b0);
    run_phase(32'd2, 32'd2, 300, 1'b0);
    run_phase(32'd33, 32'd4097, 400, 1'b0);

    settle();
    if (fails == 0 && blur_due.size() == 0) begin
      $display("gaussian_blur_3x3 test passed");
    end else begin
      $display("gaussian_blur_3x3 test failed");
    end
    $finish;
  end

endmodule
